>>> sv/assert_macros.svh
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_IMPL(lbl, clk, rstn, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rstn, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) else $error("assertion failed");
`endif

>>> sv/qnr_pkg.sv
`default_nettype none
package qnr_pkg;
	localparam int STATUS_W = 2;
	localparam int STEPS_W = 16;
	localparam logic [STATUS_W-1:0] ST_CONV = 2'd0;
	localparam logic [STATUS_W-1:0] ST_CAP = 2'd1;
	localparam logic [STATUS_W-1:0] ST_ZDER = 2'd2;
	localparam logic [2:0] REG_C4 = 3'd0;
	localparam logic [2:0] REG_C3 = 3'd1;
	localparam logic [2:0] REG_C2 = 3'd2;
	localparam logic [2:0] REG_C1 = 3'd3;
	localparam logic [2:0] REG_C0 = 3'd4;
	localparam logic [2:0] REG_MAXIT = 3'd5;
	localparam logic [15:0] MAXIT_RESET = 16'd10000;
	typedef struct packed {
		logic start;
		logic busy;
		logic done;
	} div_ctl_t;
endpackage
`default_nettype wire

>>> sv/quartic_newton_root_core.sv
`default_nettype none
// Newton-Raphson root finder for a quartic with five Q16.16 coefficients set through the
// register port. One start_x beat yields one result beat. Each Newton step runs a setup
// state, multiply-accumulate states on one shared multiplier, a derivative test, the
// bit-serial divider and an update state. A solve that stops on a zero derivative ends
// after the derivative test of its last partial step, without dividing or updating.
// The input is not ready until the result beat has been taken.
module quartic_newton_root_core #(
	parameter int DATA_WIDTH = 32,
	parameter int FRAC_BITS = 16
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         cfg_we,
	input  wire  [2:0]  cfg_index,
	input  wire  [31:0] cfg_data,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [31:0] s_tdata,   // start_x[31:0]
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [55:0] m_tdata    // root[31:0], steps_used[47:32], status[49:48]
);
	import qnr_pkg::*;
	localparam int DW = DATA_WIDTH;
	localparam int FB = FRAC_BITS;
	localparam int PW = 2 * DW;
	localparam logic signed [DW-1:0] MAXV = {1'b0, {(DW-1){1'b1}}};
	localparam logic signed [DW-1:0] MINV = {1'b1, {(DW-1){1'b0}}};
	localparam logic [3:0] S_IDLE = 4'd0, S_MAC = 4'd1, S_CHK = 4'd2, S_DIV = 4'd3,
		S_UPD = 4'd4, S_OUT = 4'd5, S_PREP = 4'd6;

	function automatic logic signed [DW-1:0] clip32(input logic [31:0] v);
		logic signed [63:0] w;
		w = 64'(signed'(v));
		if (w > 64'(MAXV)) return MAXV;
		if (w < 64'(MINV)) return MINV;
		return DW'(w);
	endfunction
	function automatic logic signed [DW-1:0] sadd(input logic signed [DW-1:0] a,
			input logic signed [DW-1:0] b);
		logic signed [DW:0] s;
		s = {a[DW-1], a} + {b[DW-1], b};
		if (s[DW] != s[DW-1]) return s[DW] ? MINV : MAXV;
		return s[DW-1:0];
	endfunction
	function automatic logic signed [DW-1:0] ssub(input logic signed [DW-1:0] a,
			input logic signed [DW-1:0] b);
		logic signed [DW:0] s;
		s = {a[DW-1], a} - {b[DW-1], b};
		if (s[DW] != s[DW-1]) return s[DW] ? MINV : MAXV;
		return s[DW-1:0];
	endfunction

	logic signed [DW-1:0] c4_q, c3_q, c2_q, c1_q, c0_q;
	logic [15:0] maxit_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c4_q <= '0; c3_q <= '0; c2_q <= '0; c1_q <= '0; c0_q <= '0;
			maxit_q <= MAXIT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_C4: c4_q <= clip32(cfg_data);
				REG_C3: c3_q <= clip32(cfg_data);
				REG_C2: c2_q <= clip32(cfg_data);
				REG_C1: c1_q <= clip32(cfg_data);
				REG_C0: c0_q <= clip32(cfg_data);
				REG_MAXIT: maxit_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	logic [3:0] state_q;
	logic [2:0] k_q;
	logic signed [DW-1:0] x_q, p_q, d_q, d4_q, d3_q, d2_q;
	logic [15:0] steps_q, lim_q;
	logic [1:0] stat_q;
	logic neg_q;

	// Shared multiplier: accumulator k_q even = poly, odd = derivative.
	logic signed [DW-1:0] ma, mc, prod;
	logic [DW-1:0] am, xm;
	logic [PW-1:0] mp, mr;
	logic mneg, mover;
	logic [DW:0] lim;
	always_comb begin
		ma = k_q[0] ? d_q : p_q;
		unique case (k_q)
			3'd0: mc = c3_q;
			3'd1: mc = d3_q;
			3'd2: mc = c2_q;
			3'd3: mc = d2_q;
			3'd4: mc = c1_q;
			3'd5: mc = c1_q;
			default: mc = c0_q;
		endcase
		am = ma[DW-1] ? DW'(-ma) : DW'(ma);
		xm = x_q[DW-1] ? DW'(-x_q) : DW'(x_q);
		mneg = ma[DW-1] ^ x_q[DW-1];
		mp = PW'(am) * PW'(xm);
		mr = mp + (PW'(1) << (FB - 1));
		mover = |(mr >> (FB + DW));
		lim = mneg ? {2'b01, {(DW-1){1'b0}}} : {2'b0, {(DW-1){1'b1}}};
		if (mover || (DW+1)'(mr >> FB) > lim) prod = mneg ? MINV : MAXV;
		else prod = mneg ? -DW'(mr >> FB) : DW'(mr >> FB);
	end

	div_ctl_t dctl;
	logic dover;
	logic [DW+FB-1:0] dquo;
	logic [DW-1:0] pmag, dmag;
	logic signed [DW-1:0] qv;
	assign pmag = p_q[DW-1] ? DW'(-p_q) : DW'(p_q);
	assign dmag = d_q[DW-1] ? DW'(-d_q) : DW'(d_q);
	assign dctl.start = (state_q == S_CHK) && (d_q != '0);
	qnr_div #(.DW(DW), .FB(FB)) u_div (
		.clk(clk), .arst_n(arst_n), .start(dctl.start), .num_mag(pmag), .den_mag(dmag),
		.busy(dctl.busy), .done(dctl.done), .over(dover), .quo(dquo)
	);
	always_comb begin
		if (neg_q) qv = (dover || dquo[DW-1:0] > DW'(MINV)) ? MINV : -dquo[DW-1:0];
		else qv = (dover || dquo[DW-1]) ? MAXV : dquo[DW-1:0];
	end

	logic signed [DW-1:0] nx;
	assign nx = ssub(x_q, qv);
	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = (state_q == S_OUT);
	logic signed [31:0] rootv;
	always_comb begin
		if (DW > 32 && x_q > DW'(signed'(32'h7fffffff))) rootv = 32'h7fffffff;
		else if (DW > 32 && x_q < DW'(signed'(32'h80000000))) rootv = 32'h80000000;
		else rootv = 32'(x_q);
	end
	assign m_tdata = {6'd0, stat_q, steps_q, rootv};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			k_q <= '0;
			steps_q <= '0;
			stat_q <= ST_CAP;
		end else begin
			unique case (state_q)
				S_IDLE: if (s_tvalid) begin
					state_q <= S_PREP;
					steps_q <= '0;
					stat_q <= ST_CAP;
				end
				S_PREP: begin
					k_q <= '0;
					state_q <= S_MAC;
				end
				S_MAC: begin
					k_q <= k_q + 1'b1;
					if (k_q == 3'd7) state_q <= S_CHK;
				end
				S_CHK: if (d_q == '0) begin
					stat_q <= ST_ZDER;
					state_q <= S_OUT;
				end else state_q <= S_DIV;
				S_DIV: if (dctl.done) state_q <= S_UPD;
				S_UPD: begin
					steps_q <= steps_q + 1'b1;
					if (nx == x_q) begin
						stat_q <= ST_CONV;
						state_q <= S_OUT;
					end else if (steps_q + 1'b1 >= lim_q) state_q <= S_OUT;
					else state_q <= S_PREP;
				end
				S_OUT: if (m_tready) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: if (s_tvalid) begin
				x_q <= clip32(s_tdata);
				lim_q <= (maxit_q == '0) ? 16'd1 : maxit_q;
				d4_q <= sadd(sadd(c4_q, c4_q), sadd(c4_q, c4_q));
				d3_q <= sadd(sadd(c3_q, c3_q), c3_q);
				d2_q <= sadd(c2_q, c2_q);
			end
			S_PREP: begin
				p_q <= c4_q;
				d_q <= d4_q;
			end
			S_MAC: if (k_q <= 3'd6) begin
				if (k_q[0]) d_q <= sadd(prod, mc);
				else p_q <= sadd(prod, mc);
			end
			S_CHK: neg_q <= p_q[DW-1] ^ d_q[DW-1];
			S_UPD: x_q <= nx;
			default: ;
		endcase
	end

	`include "assert_macros.svh"
	`ASSERT_IMPL(a_hs_excl, clk, arst_n, m_tvalid, !s_tready)
	`ASSERT_IMPL(a_div_idle, clk, arst_n, dctl.busy, state_q == S_DIV)
	`ASSERT_NEXT(a_zder_keep, clk, arst_n, state_q == S_CHK && d_q == '0, stat_q == ST_ZDER)
endmodule
`default_nettype wire

>>> sv/qnr_div.sv
`default_nettype none
module qnr_div #(
	parameter int DW = 32,
	parameter int FB = 16
) (
	input  wire             clk,
	input  wire             arst_n,
	input  wire             start,
	input  wire  [DW-1:0]   num_mag,
	input  wire  [DW-1:0]   den_mag,
	output logic            busy,
	output logic            done,
	output logic            over,
	output logic [DW+FB-1:0] quo
);
	localparam int NB = DW + FB;
	localparam int CW = $clog2(NB + 1);
	logic [NB-1:0] dvd_q;
	logic [DW:0]   rem_q;
	logic [DW-1:0] den_q;
	logic [CW-1:0] cnt_q;
	logic [DW:0]   trial;
	assign trial = {rem_q[DW-1:0], dvd_q[NB-1]};
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy <= 1'b0;
			done <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy <= 1'b1;
				cnt_q <= CW'(NB);
			end else if (busy) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= {num_mag, {FB{1'b0}}};
			rem_q <= '0;
			den_q <= den_mag;
			quo <= '0;
		end else if (busy) begin
			dvd_q <= dvd_q << 1;
			quo <= quo << 1;
			if (trial >= {1'b0, den_q}) begin
				rem_q <= trial - {1'b0, den_q};
				quo[0] <= 1'b1;
			end else begin
				rem_q <= trial;
				quo[0] <= 1'b0;
			end
		end
	end
	assign over = |quo[NB-1:DW-1];
endmodule
`default_nettype wire
